>>> rtl/slc_pkg.sv
// Shared types, constants and register codes for the sound and light lamp controller.
// Used by every module in this folder; depends on nothing else.
`default_nettype none

package slc_pkg;

    localparam int SAMPLE_W = 14;
    localparam int LUX_W = 17;
    localparam int HOLD_W = 16;
    localparam int ACTION_W = 2;
    localparam int MODE_W = 2;
    localparam int LED_W = 3;
    localparam int COLOUR_W = 2;
    localparam int AVG_W = 14;

    localparam int RECENT_DEPTH_DEF = 10;
    localparam int HISTORY_DEPTH_DEF = 50;

    localparam logic [LUX_W-1:0] LUX_RESET = 17'd2000;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd100;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_LUX = 1'b0;
    localparam logic REG_HOLD = 1'b1;

    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BTN1 = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_BTN2 = 2'd2;

    localparam logic [COLOUR_W-1:0] COLOUR_RED = 2'd0;
    localparam logic [COLOUR_W-1:0] COLOUR_BLUE = 2'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_INIT = 2'd0,
        MODE_ON = 2'd1,
        MODE_OFF = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_COUNT = 2'd1,
        PH_EXPIRED = 2'd2
    } t_phase;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SAMPLE_W-1:0] sound_sample;
        logic [LUX_W-1:0] light_level;
    } t_in_item;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [LED_W-1:0] led_drive;
        logic [HOLD_W-1:0] countdown;
        logic activity;
        logic [AVG_W-1:0] recent_average;
        logic [AVG_W-1:0] history_average;
    } t_out_item;

    typedef struct packed {
        logic valid;
        logic [ACTION_W-1:0] action;
        logic [LUX_W-1:0] light_level;
        logic [AVG_W-1:0] recent_average;
        logic [AVG_W-1:0] history_average;
    } t_stat;

    typedef struct packed {
        logic [LUX_W-1:0] lux_threshold;
        logic [HOLD_W-1:0] hold_ticks;
    } t_cfg;

endpackage

`default_nettype wire

>>> rtl/sound_light_lamp_controller.sv
// Sound and light lamp controller: one item per clock cycle is accepted back to back, and its
// result passes through the ring memory read at acceptance, the running-total update with
// write-back, the reciprocal multiply for the averages, then the lamp state update into the
// result register. Each ring memory is read and written once per tick item, which sets the
// one-item-per-cycle rate. A result held by a low output ready stalls the pipeline, and input
// ready falls only once every stage holds an item.
// Rings read as zero after reset through per-entry valid bits, so there is no clearing pass.
// The two APB registers sit at byte addresses 0 (lux_threshold) and 4 (hold_ticks).
`default_nettype none

module sound_light_lamp_controller #(
    parameter int RECENT_DEPTH = slc_pkg::RECENT_DEPTH_DEF,
    parameter int HISTORY_DEPTH = slc_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire slc_pkg::t_in_item             i_in_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output slc_pkg::t_out_item                 o_out_item,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [slc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [slc_pkg::PDATA_W-1:0]   pwdata,
    output logic      [slc_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    logic [slc_pkg::LUX_W-1:0]  r_lux;
    logic [slc_pkg::HOLD_W-1:0] r_hold;
    logic                       cfg_write;
    slc_pkg::t_cfg              cfg;
    slc_pkg::t_stat             stat;
    logic                       stat_ready;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lux <= slc_pkg::LUX_RESET;
            r_hold <= slc_pkg::HOLD_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                slc_pkg::REG_LUX: begin
                    r_lux <= pwdata[slc_pkg::LUX_W-1:0];
                end
                slc_pkg::REG_HOLD: begin
                    r_hold <= pwdata[slc_pkg::HOLD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            slc_pkg::REG_LUX: prdata = slc_pkg::PDATA_W'(r_lux);
            slc_pkg::REG_HOLD: prdata = slc_pkg::PDATA_W'(r_hold);
            default: prdata = '0;
        endcase
    end

    always_comb begin
        cfg.lux_threshold = r_lux;
        cfg.hold_ticks = r_hold;
    end

    slc_sound #(
        .RECENT_DEPTH(RECENT_DEPTH),
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_sound (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_item(i_in_item),
        .o_stat(stat),
        .i_stat_ready(stat_ready)
    );

    slc_lamp u_lamp (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_stat(stat),
        .o_stat_ready(stat_ready),
        .i_cfg(cfg),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item(o_out_item)
    );

endmodule

`default_nettype wire

>>> rtl/slc_ring_mem.sv
// Sample ring memory with one registered read port and one write port.
// Unwritten entries read as zero through per-entry valid bits; uses slc_pkg.
`default_nettype none

module slc_ring_mem #(
    parameter int DEPTH = slc_pkg::RECENT_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]           i_rd_addr,
    output logic      [slc_pkg::SAMPLE_W-1:0]       o_rd_data,
    input  wire logic                               i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]           i_wr_addr,
    input  wire logic [slc_pkg::SAMPLE_W-1:0]       i_wr_data
);

    logic [slc_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]             r_valid;
    logic [slc_pkg::SAMPLE_W-1:0] r_rd_data;
    logic                         r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

`default_nettype wire

>>> rtl/slc_sound.sv
// Sound front end: ring pointers, ring memories, running totals and truncated averages.
// Instantiates slc_ring_mem twice; uses slc_pkg types and constants.
`default_nettype none

module slc_sound #(
    parameter int RECENT_DEPTH = slc_pkg::RECENT_DEPTH_DEF,
    parameter int HISTORY_DEPTH = slc_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire slc_pkg::t_in_item i_in_item,
    output slc_pkg::t_stat         o_stat,
    input  wire logic              i_stat_ready
);

    localparam int SW = slc_pkg::SAMPLE_W;
    localparam int AW = slc_pkg::AVG_W;
    localparam int RAW = $clog2(RECENT_DEPTH);
    localparam int HAW = $clog2(HISTORY_DEPTH);
    localparam int RTW = SW + RAW;
    localparam int HTW = SW + HAW;
    localparam int RSH = RTW + RAW;
    localparam int HSH = HTW + HAW;
    localparam longint unsigned RMUL_L =
        ((64'd1 << RSH) + 64'(RECENT_DEPTH) - 64'd1) / 64'(RECENT_DEPTH);
    localparam longint unsigned HMUL_L =
        ((64'd1 << HSH) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH);
    localparam logic [RTW:0] RMUL = (RTW+1)'(RMUL_L);
    localparam logic [HTW:0] HMUL = (HTW+1)'(HMUL_L);
    localparam logic [RAW-1:0] RLAST = RAW'(RECENT_DEPTH - 1);
    localparam logic [HAW-1:0] HLAST = HAW'(HISTORY_DEPTH - 1);

    logic en1;
    logic en2;
    logic en3;
    logic accept;
    logic tick_acc;
    logic s1_tick;
    logic s1_write;

    logic [RAW-1:0] r_rptr;
    logic [HAW-1:0] r_hptr;
    logic [RTW-1:0] r_rtotal;
    logic [HTW-1:0] r_htotal;

    logic                          r_v1;
    logic [slc_pkg::ACTION_W-1:0]  r_s1_action;
    logic [slc_pkg::LUX_W-1:0]     r_s1_light;
    logic [SW-1:0]                 r_s1_sample;
    logic [RAW-1:0]                r_s1_rptr;
    logic [HAW-1:0]                r_s1_hptr;

    logic                          r_v2;
    logic [slc_pkg::ACTION_W-1:0]  r_s2_action;
    logic [slc_pkg::LUX_W-1:0]     r_s2_light;
    logic [RTW-1:0]                r_s2_rtotal;
    logic [HTW-1:0]                r_s2_htotal;

    logic                          r_v3;
    logic [slc_pkg::ACTION_W-1:0]  r_s3_action;
    logic [slc_pkg::LUX_W-1:0]     r_s3_light;
    logic [AW-1:0]                 r_s3_ravg;
    logic [AW-1:0]                 r_s3_havg;

    logic [SW-1:0]    leaving;
    logic [SW-1:0]    old_hist;
    logic [RTW-1:0]   n_rtotal;
    logic [HTW-1:0]   n_htotal;
    logic [2*RTW:0]   rprod;
    logic [2*HTW:0]   hprod;

    assign en3 = !r_v3 || i_stat_ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_in_ready = en1;
    assign accept = i_in_valid && en1;
    assign tick_acc = accept && (i_in_item.action == slc_pkg::ACT_TICK);
    assign s1_tick = r_s1_action == slc_pkg::ACT_TICK;
    assign s1_write = r_v1 && en2 && s1_tick;

    slc_ring_mem #(
        .DEPTH(RECENT_DEPTH)
    ) u_recent (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_rd_en(tick_acc),
        .i_rd_addr(r_rptr),
        .o_rd_data(leaving),
        .i_wr_en(s1_write),
        .i_wr_addr(r_s1_rptr),
        .i_wr_data(r_s1_sample)
    );

    slc_ring_mem #(
        .DEPTH(HISTORY_DEPTH)
    ) u_history (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_rd_en(tick_acc),
        .i_rd_addr(r_hptr),
        .o_rd_data(old_hist),
        .i_wr_en(s1_write),
        .i_wr_addr(r_s1_hptr),
        .i_wr_data(leaving)
    );

    always_comb begin
        n_rtotal = r_rtotal - RTW'(leaving) + RTW'(r_s1_sample);
        n_htotal = r_htotal - HTW'(old_hist) + HTW'(leaving);
    end

    assign rprod = (2*RTW+1)'(r_s2_rtotal) * (2*RTW+1)'(RMUL);
    assign hprod = (2*HTW+1)'(r_s2_htotal) * (2*HTW+1)'(HMUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rptr <= '0;
            r_hptr <= '0;
            r_rtotal <= '0;
            r_htotal <= '0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (tick_acc) begin
                r_rptr <= (r_rptr == RLAST) ? '0 : r_rptr + 1'b1;
                r_hptr <= (r_hptr == HLAST) ? '0 : r_hptr + 1'b1;
            end
            if (s1_write) begin
                r_rtotal <= n_rtotal;
                r_htotal <= n_htotal;
            end
            if (en1) begin
                r_v1 <= i_in_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_action <= i_in_item.action;
            r_s1_light <= i_in_item.light_level;
            r_s1_sample <= i_in_item.sound_sample;
            r_s1_rptr <= r_rptr;
            r_s1_hptr <= r_hptr;
        end
        if (r_v1 && en2) begin
            r_s2_action <= r_s1_action;
            r_s2_light <= r_s1_light;
            r_s2_rtotal <= s1_tick ? n_rtotal : r_rtotal;
            r_s2_htotal <= s1_tick ? n_htotal : r_htotal;
        end
        if (r_v2 && en3) begin
            r_s3_action <= r_s2_action;
            r_s3_light <= r_s2_light;
            r_s3_ravg <= rprod[RSH +: AW];
            r_s3_havg <= hprod[HSH +: AW];
        end
    end

    always_comb begin
        o_stat.valid = r_v3;
        o_stat.action = r_s3_action;
        o_stat.light_level = r_s3_light;
        o_stat.recent_average = r_s3_ravg;
        o_stat.history_average = r_s3_havg;
    end

    a_rptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rptr <= RLAST)
        else $error("recent ring pointer out of range");

    a_hptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hptr <= HLAST)
        else $error("history ring pointer out of range");

    a_rtotal_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && en2 |=> {2'b00, r_rtotal} <= (RTW+2)'(RECENT_DEPTH * ((1 << SW) - 1)))
        else $error("recent total exceeds the ring capacity");

endmodule

`default_nettype wire

>>> rtl/slc_lamp.sv
// Lamp control: activity test, countdown, mode and colour logic, and the result register.
// Fed by slc_sound through a t_stat struct; uses slc_pkg types and constants.
`default_nettype none

module slc_lamp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire slc_pkg::t_stat  i_stat,
    output logic                 o_stat_ready,
    input  wire slc_pkg::t_cfg   i_cfg,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output slc_pkg::t_out_item   o_out_item
);

    localparam int AW = slc_pkg::AVG_W;

    slc_pkg::t_mode  r_mode;
    slc_pkg::t_mode  n_mode;
    slc_pkg::t_phase r_phase;
    slc_pkg::t_phase n_phase;
    logic                            r_first;
    logic                            n_first;
    logic [slc_pkg::HOLD_W-1:0]      r_remaining;
    logic [slc_pkg::HOLD_W-1:0]      n_remaining;
    logic [slc_pkg::COLOUR_W-1:0]    r_colour;
    logic [slc_pkg::COLOUR_W-1:0]    n_colour;
    logic                            r_out_valid;
    slc_pkg::t_out_item              r_out_item;
    slc_pkg::t_out_item              n_out_item;

    logic          en;
    logic          take;
    logic [AW-1:0] diff;
    logic [AW+3:0] tenfold;
    logic          act;

    assign en = !r_out_valid || i_out_ready;
    assign take = i_stat.valid && en;
    assign o_stat_ready = en;

    // Deviation exceeds a truncated tenth of the history mean exactly when ten times it
    // exceeds the history mean itself.
    always_comb begin
        if (i_stat.recent_average > i_stat.history_average) begin
            diff = i_stat.recent_average - i_stat.history_average;
        end else begin
            diff = i_stat.history_average - i_stat.recent_average;
        end
        tenfold = {1'b0, diff, 3'b000} + {3'b000, diff, 1'b0};
        act = (AW+4)'(i_stat.history_average) < tenfold;
    end

    always_comb begin
        n_mode = r_mode;
        n_phase = r_phase;
        n_first = r_first;
        n_remaining = r_remaining;
        n_colour = r_colour;
        unique case (i_stat.action)
            slc_pkg::ACT_TICK: begin
                if (r_phase == slc_pkg::PH_COUNT) begin
                    if (r_remaining != '0) begin
                        n_remaining = r_remaining - 1'b1;
                    end else begin
                        n_phase = slc_pkg::PH_EXPIRED;
                        n_remaining = i_cfg.hold_ticks;
                    end
                end
                if (r_mode == slc_pkg::MODE_ON) begin
                    if (!r_first) begin
                        n_first = 1'b1;
                        if (i_stat.light_level > i_cfg.lux_threshold) begin
                            n_mode = slc_pkg::MODE_OFF;
                        end
                    end
                    if (n_phase == slc_pkg::PH_IDLE) begin
                        n_phase = slc_pkg::PH_COUNT;
                        n_remaining = i_cfg.hold_ticks;
                    end else if (n_phase == slc_pkg::PH_EXPIRED) begin
                        n_phase = slc_pkg::PH_IDLE;
                        n_mode = slc_pkg::MODE_OFF;
                    end
                    if (act) begin
                        n_remaining = i_cfg.hold_ticks;
                    end
                end else if (r_mode == slc_pkg::MODE_OFF) begin
                    n_remaining = i_cfg.hold_ticks;
                    if (act && (i_stat.light_level < i_cfg.lux_threshold)) begin
                        n_mode = slc_pkg::MODE_ON;
                    end
                end
            end
            slc_pkg::ACT_BTN1: begin
                n_mode = (r_mode == slc_pkg::MODE_ON) ? slc_pkg::MODE_OFF : slc_pkg::MODE_ON;
            end
            slc_pkg::ACT_BTN2: begin
                if (r_mode == slc_pkg::MODE_INIT) begin
                    n_colour = (r_colour < slc_pkg::COLOUR_BLUE) ? r_colour + 1'b1
                                                                 : slc_pkg::COLOUR_RED;
                end else if (r_mode == slc_pkg::MODE_ON) begin
                    n_remaining = i_cfg.hold_ticks;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_item.mode = n_mode;
        if (n_mode == slc_pkg::MODE_OFF) begin
            n_out_item.led_drive = '0;
        end else begin
            n_out_item.led_drive = slc_pkg::LED_W'(1) << n_colour;
        end
        n_out_item.countdown = n_remaining;
        n_out_item.activity = act;
        n_out_item.recent_average = i_stat.recent_average;
        n_out_item.history_average = i_stat.history_average;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= slc_pkg::MODE_INIT;
            r_phase <= slc_pkg::PH_IDLE;
            r_first <= 1'b0;
            r_remaining <= slc_pkg::HOLD_RESET;
            r_colour <= slc_pkg::COLOUR_RED;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_mode <= n_mode;
                r_phase <= n_phase;
                r_first <= n_first;
                r_remaining <= n_remaining;
                r_colour <= n_colour;
            end
            if (en) begin
                r_out_valid <= i_stat.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out_item;

    a_first_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_first |=> r_first)
        else $error("brightness check flag cleared after being set");

    a_no_return_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != slc_pkg::MODE_INIT |=> r_mode != slc_pkg::MODE_INIT)
        else $error("lamp mode returned to init");

    a_led_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $onehot0(r_out_item.led_drive))
        else $error("lamp drive is not one-hot");

endmodule

`default_nettype wire
